[rtl/ibfr_pkg.sv]
// Package for the servo-frame receiver: frame constants, result kinds and stream widths.
// No dependencies; imported by ibus_frame_receiver.
package ibfr_pkg;

  // Frame layout
  localparam int unsigned CHANNELS    = 14;
  localparam int unsigned FRAME_BYTES = 32;
  localparam int unsigned CSUM_BYTES  = 30;
  localparam int unsigned WORDS       = FRAME_BYTES / 2;
  localparam int unsigned POS_W       = $clog2(FRAME_BYTES);
  localparam int unsigned WIDX_W      = $clog2(WORDS);

  localparam logic [7:0]  HDR0       = 8'h20;
  localparam logic [7:0]  HDR1       = 8'h40;
  localparam logic [15:0] CSUM_SEED  = 16'hFFFF;
  localparam logic [31:0] TIMEOUT_RST = 32'd100;

  // Stream widths
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned IN_TUSER_W  = 1;
  localparam int unsigned OUT_TDATA_W = 120;
  localparam int unsigned OUT_TUSER_W = 2;

  // Input word kinds
  localparam logic CMD_BYTE     = 1'b0;
  localparam logic CMD_LINE_ERR = 1'b1;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_CHAN     = 2'd0,
    KIND_CSUM_ERR = 2'd1,
    KIND_LINE_ERR = 2'd2
  } kind_e;

endpackage

[rtl/ibus_frame_receiver.sv]
// Servo-frame receiver: header hunt, running checksum, channel readout and link status.
// Depends on ibfr_pkg.
//
// Channel    Dir  Handshake               Payload
// s_axis     in   tvalid/tready           tuser: command; tdata: rx_data, time_ms
// m_axis     out  tvalid/tready, tlast    tuser: result_kind; tdata: index, value, totals
// cfg        in   cfg_we_i                cfg_wdata_i: online_timeout_ms
//
// A byte that does not end a frame is taken and the block stays ready for the next byte.
// A frame end passes the check and age states, then its results leave the single output
// register one per cycle while free: 14 channel results or one checksum error. A line
// error goes via the age state to one result. Input waits; stalls hold the sequencer.
// Reset clears the hunt, counters and flags; the frame store needs no clearing.
module ibus_frame_receiver (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // online_timeout_ms
  input  logic                               cfg_we_i,
  input  logic [31:0]                        cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [7:0] rx_data, [39:8] time_ms
  input  logic [ibfr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [0] command
  input  logic [ibfr_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [3:0] channel_index, [19:4] channel_value, [51:20] good_frame_total,
  // [83:52] error_total, [115:84] stamp_ms, [116] online, [119:117] zero
  output logic [ibfr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // [1:0] result_kind
  output logic [ibfr_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
  output logic                               m_axis_tlast
);
  import ibfr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_AGE,
    ST_EMIT
  } state_e;

  localparam logic [3:0]       CHAN_LAST = 4'(CHANNELS - 1);
  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] POS_CSUM  = POS_W'(CSUM_BYTES);
  localparam logic [POS_W-1:0] POS_HDR1  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_BODY  = POS_W'(2);

  state_e           state_q, state_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [15:0]      sum_q, sum_d;
  logic [31:0]      now_q, now_d;
  logic [31:0]      stamp_q, stamp_d;
  logic [31:0]      good_q, good_d;
  logic [31:0]      bad_q, bad_d;
  logic [31:0]      timeout_q, timeout_d;
  logic             seen_q, seen_d;
  logic             online_q, online_d;
  kind_e            kind_q, kind_d;
  logic [3:0]       ch_q, ch_d;

  logic             m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0] m_data_q, m_data_d;
  kind_e            m_kind_q, m_kind_d;
  logic             m_last_q, m_last_d;

  // Frame store: one 16-bit word per byte pair
  logic [15:0]      word_q [WORDS];

  logic             in_acc;
  logic             in_cmd;
  logic [7:0]       in_byte;
  logic [31:0]      in_time;
  logic             out_free;
  logic [31:0]      age;
  logic [WIDX_W-1:0] rd_idx;
  logic             emit_last;
  logic [3:0]       emit_idx;
  logic [15:0]      emit_val;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_cmd   = s_axis_tuser[0];
  assign in_byte  = s_axis_tdata[7:0];
  assign in_time  = s_axis_tdata[39:8];
  assign out_free = !m_valid_q || m_axis_tready;
  assign age      = now_q - stamp_q;
  assign rd_idx   = WIDX_W'(ch_q + 4'd1);

  // Fields of the result being loaded this cycle
  always_comb begin
    emit_last = (kind_q != KIND_CHAN) || (ch_q == CHAN_LAST);
    emit_idx  = (kind_q == KIND_CHAN) ? ch_q : 4'd0;
    emit_val  = (kind_q == KIND_CHAN) ? word_q[rd_idx] : 16'd0;
  end

  // Sequencer: hunt, accumulate, check, age, emit
  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    sum_d     = sum_q;
    now_d     = now_q;
    stamp_d   = stamp_q;
    good_d    = good_q;
    bad_d     = bad_q;
    timeout_d = timeout_q;
    seen_d    = seen_q;
    online_d  = online_q;
    kind_d    = kind_q;
    ch_d      = ch_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_kind_d  = m_kind_q;
    m_last_d  = m_last_q;

    if (cfg_we_i) begin
      timeout_d = cfg_wdata_i;
    end

    // Drop the output word once taken
    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          now_d = in_time;
          if (in_cmd == CMD_LINE_ERR) begin
            bad_d   = bad_q + 32'd1;
            pos_d   = '0;
            kind_d  = KIND_LINE_ERR;
            state_d = ST_AGE;
          end else if (pos_q == '0) begin
            if (in_byte == HDR0) begin
              pos_d = POS_HDR1;
              sum_d = CSUM_SEED - {8'h00, in_byte};
            end
          end else if (pos_q == POS_HDR1) begin
            if (in_byte == HDR1) begin
              pos_d = POS_BODY;
              sum_d = sum_q - {8'h00, in_byte};
            end else begin
              pos_d = '0;
            end
          end else begin
            pos_d = pos_q + POS_W'(1);
            if (pos_q < POS_CSUM) begin
              sum_d = sum_q - {8'h00, in_byte};
            end
            if (pos_q == POS_LAST) begin
              pos_d   = '0;
              state_d = ST_CHECK;
            end
          end
        end
      end
      ST_CHECK: begin
        if (sum_q == word_q[WORDS-1]) begin
          good_d  = good_q + 32'd1;
          stamp_d = now_q;
          seen_d  = 1'b1;
          kind_d  = KIND_CHAN;
        end else begin
          bad_d  = bad_q + 32'd1;
          kind_d = KIND_CSUM_ERR;
        end
        state_d = ST_AGE;
      end
      ST_AGE: begin
        online_d = seen_q && (age < timeout_q);
        ch_d     = 4'd0;
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_kind_d  = kind_q;
          m_last_d  = emit_last;
          m_data_d  = {3'b000, online_q, stamp_q, bad_q, good_q, emit_val, emit_idx};
          ch_d      = ch_q + 4'd1;
          if (emit_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state, counters and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pos_q     <= '0;
      sum_q     <= '0;
      now_q     <= '0;
      stamp_q   <= '0;
      good_q    <= '0;
      bad_q     <= '0;
      timeout_q <= TIMEOUT_RST;
      seen_q    <= 1'b0;
      online_q  <= 1'b0;
      kind_q    <= KIND_CHAN;
      ch_q      <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_kind_q  <= KIND_CHAN;
      m_last_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      sum_q     <= sum_d;
      now_q     <= now_d;
      stamp_q   <= stamp_d;
      good_q    <= good_d;
      bad_q     <= bad_d;
      timeout_q <= timeout_d;
      seen_q    <= seen_d;
      online_q  <= online_d;
      kind_q    <= kind_d;
      ch_q      <= ch_d;
      m_valid_q <= m_valid_d;
      m_data_q  <= m_data_d;
      m_kind_q  <= m_kind_d;
      m_last_q  <= m_last_d;
    end
  end

  // Write frame body bytes into their word half
  always_ff @(posedge clk_i) begin
    if (in_acc && (in_cmd == CMD_BYTE) && (pos_q >= POS_BODY)) begin
      if (pos_q[0]) begin
        word_q[pos_q[POS_W-1:1]][15:8] <= in_byte;
      end else begin
        word_q[pos_q[POS_W-1:1]][7:0] <= in_byte;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tlast  = m_last_q;

  // Error results stand alone
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != KIND_CHAN)) |-> m_axis_tlast)
    else $error("error result without tlast");

  // A channel run ends on the last channel only
  a_chan_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == KIND_CHAN) && m_axis_tlast)
      |-> (m_axis_tdata[3:0] == CHAN_LAST))
    else $error("channel run ended early");

  // The good-frame counter moves by at most one per cycle
  a_good_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (good_q != $past(good_q)) |-> (good_q == $past(good_q) + 32'd1))
    else $error("good count jumped");

  // Input is taken only while no result run is pending
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> !s_axis_tready)
    else $error("input accepted during emission");

endmodule

[sim/tb.sv]
// Self-checking testbench for ibus_frame_receiver: directed header and frame tests, timeout
// settings, long output hold-off and random framed traffic. Depends on ibfr_pkg and the RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ibfr_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_WORDS = 24;

  typedef enum int {STALL_NONE, STALL_COIN, STALL_PATTERN, STALL_RARE} stall_mode_e;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  idx;
    logic [15:0] val;
    logic        last;
    logic [31:0] good;
    logic [31:0] bad;
    logic [31:0] stamp;
    logic        online;
  } rx_result_t;

  typedef logic [CHANNELS-1:0][15:0] chan_set_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [31:0]            cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic                   m_axis_tlast;

  // Decoder shadow state
  logic [5:0]  p_pos;
  logic [7:0]  p_store [FRAME_BYTES];
  logic        p_seen;
  logic [31:0] p_stamp;
  logic [31:0] p_good;
  logic [31:0] p_bad;
  logic [31:0] p_timeout;

  rx_result_t  decoded_q [$];

  int          err_count       = 0;
  int          results_checked = 0;
  int          items_sent      = 0;
  int          line_errs       = 0;
  int          cfg_writes      = 0;
  int          cycle_count     = 0;
  int          burst_left      = 0;
  bit          sender_gaps_on  = 1'b1;
  bit          hold_req        = 1'b0;
  int          hold_left       = 0;
  int          rx_phase        = 0;
  int unsigned rx_tick         = 0;
  stall_mode_e rx_mode         = STALL_NONE;
  logic [31:0] now_ms          = '0;

  ibus_frame_receiver i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still outstanding",
               cycle_count, decoded_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Decoder prediction
  // ---------------------------------------------------------------------------

  task automatic log_result(input kind_e kind, input logic [3:0] idx, input logic [15:0] val,
                            input logic last, input logic [31:0] now);
    rx_result_t  r;
    logic [31:0] age;
    age      = now - p_stamp;
    r.kind   = kind;
    r.idx    = idx;
    r.val    = val;
    r.last   = last;
    r.good   = p_good;
    r.bad    = p_bad;
    r.stamp  = p_stamp;
    r.online = p_seen && (age < p_timeout);
    decoded_q.push_back(r);
  endtask

  task automatic decode_rx_word(input logic cmd, input logic [7:0] b, input logic [31:0] now);
    logic [15:0] sum;
    logic [15:0] got;
    if (cmd == CMD_LINE_ERR) begin
      p_bad++;
      line_errs++;
      p_pos = '0;
      log_result(KIND_LINE_ERR, 4'd0, 16'd0, 1'b1, now);
    end else if (p_pos == 0) begin
      // hunt for the first header byte, drop anything else
      if (b == HDR0) begin
        p_store[0] = HDR0;
        p_pos      = 6'd1;
      end
    end else if (p_pos == 1) begin
      // a wrong second byte restarts the hunt and is not reused
      if (b == HDR1) begin
        p_store[1] = HDR1;
        p_pos      = 6'd2;
      end else begin
        p_pos = '0;
      end
    end else begin
      p_store[p_pos[4:0]] = b;
      p_pos = p_pos + 6'd1;
      if (p_pos >= FRAME_BYTES) begin
        p_pos = '0;
        sum   = CSUM_SEED;
        for (int i = 0; i < CSUM_BYTES; i++) sum = sum - 16'(p_store[i]);
        got = {p_store[31], p_store[30]};
        if (sum != got) begin
          p_bad++;
          log_result(KIND_CSUM_ERR, 4'd0, 16'd0, 1'b1, now);
        end else begin
          p_stamp = now;
          p_seen  = 1'b1;
          p_good++;
          for (int i = 0; i < CHANNELS; i++) begin
            log_result(KIND_CHAN, 4'(i), {p_store[3 + 2 * i], p_store[2 + 2 * i]},
                       (i == CHANNELS - 1), now);
          end
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    if (err_count <= 40) begin
      $display("ERROR @%0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk_i) begin : result_check
    rx_result_t want;
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("result word with nothing outstanding, kind", 32'(m_axis_tuser), 0);
      end else begin
        want = decoded_q.pop_front();
        results_checked++;
        check_field("result_kind",      32'(m_axis_tuser),          32'(want.kind));
        check_field("channel_index",    32'(m_axis_tdata[3:0]),     32'(want.idx));
        check_field("channel_value",    32'(m_axis_tdata[19:4]),    32'(want.val));
        check_field("good_frame_total", m_axis_tdata[51:20],        want.good);
        check_field("error_total",      m_axis_tdata[83:52],        want.bad);
        check_field("stamp_ms",         m_axis_tdata[115:84],       want.stamp);
        check_field("online",           32'(m_axis_tdata[116]),     32'(want.online));
        check_field("tdata padding",    32'(m_axis_tdata[OUT_TDATA_W-1:117]), 32'd0);
        check_field("tlast",            32'(m_axis_tlast),          32'(want.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: stall patterns and the long hold-off
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin : rx_stall
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      if (rx_phase == 0) begin
        rx_mode  = stall_mode_e'($urandom_range(0, 3));
        rx_phase = $urandom_range(50, 300);
      end
      rx_phase--;
      case (rx_mode)
        STALL_NONE:    m_axis_tready <= 1'b1;
        STALL_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
        STALL_PATTERN: m_axis_tready <= (rx_tick[1:0] == 2'd0);
        default:       m_axis_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
    rx_tick++;
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] advance_time();
    int r;
    r = $urandom_range(0, 63);
    if (r == 0) now_ms = $urandom();
    else if (r == 1) now_ms = now_ms + $urandom_range(100, 5000);
    else now_ms = now_ms + $urandom_range(0, 4);
    return now_ms;
  endfunction

  // Offer one word; the sender runs in bursts with random gaps between them
  task automatic send_word(input logic cmd, input logic [7:0] b, input logic [31:0] t);
    int gap;
    int r;
    if (burst_left == 0) begin
      gap = 0;
      if (sender_gaps_on) begin
        r = $urandom_range(0, 9);
        if (r >= 9) gap = $urandom_range(10, 40);
        else if (r >= 4) gap = $urandom_range(1, 5);
      end
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {t, b};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    decode_rx_word(cmd, b, t);
    burst_left--;
    items_sent++;
  endtask

  // Send the first len bytes of a frame; corrupt flips one bit after the header
  task automatic send_frame(input chan_set_t ch, input bit corrupt, input int len);
    logic [7:0]  fr [FRAME_BYTES];
    logic [15:0] sum;
    int          k;
    fr[0] = HDR0;
    fr[1] = HDR1;
    for (int i = 0; i < CHANNELS; i++) begin
      fr[2 + 2 * i] = ch[i][7:0];
      fr[3 + 2 * i] = ch[i][15:8];
    end
    sum = CSUM_SEED;
    for (int i = 0; i < CSUM_BYTES; i++) sum = sum - 16'(fr[i]);
    fr[30] = sum[7:0];
    fr[31] = sum[15:8];
    if (corrupt) begin
      k     = $urandom_range(2, FRAME_BYTES - 1);
      fr[k] = fr[k] ^ (8'h01 << $urandom_range(0, 7));
    end
    for (int i = 0; i < len; i++) send_word(CMD_BYTE, fr[i], advance_time());
  endtask

  function automatic chan_set_t random_channels();
    chan_set_t ch;
    int        r;
    for (int i = 0; i < CHANNELS; i++) begin
      r = $urandom_range(0, 9);
      if (r == 0) ch[i] = 16'h0000;
      else if (r == 1) ch[i] = 16'hFFFF;
      else ch[i] = 16'($urandom());
    end
    return ch;
  endfunction

  task automatic send_line_error(input logic [31:0] t);
    send_word(CMD_LINE_ERR, 8'($urandom()), t);
  endtask

  // Stop offering and wait until the block has delivered everything
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [31:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    p_timeout = value;
    cfg_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Header hunt: dropped first bytes, wrong second bytes, line errors in hunt, header and body
  task automatic test_header_hunt();
    send_word(CMD_LINE_ERR, 8'hFF, 32'h0000_0000);
    send_word(CMD_BYTE, 8'h00, 32'hFFFF_FFFF);
    send_word(CMD_BYTE, 8'hFF, 32'hFFFF_FFFF);
    send_word(CMD_BYTE, HDR0,  32'h0000_0001);
    send_word(CMD_BYTE, 8'h41, 32'h0000_0002);
    send_word(CMD_BYTE, HDR1,  32'h0000_0003);
    send_word(CMD_BYTE, HDR0,  32'h0000_0004);
    send_word(CMD_BYTE, HDR0,  32'h0000_0005);
    send_word(CMD_BYTE, HDR1,  32'h0000_0006);
    send_word(CMD_BYTE, HDR0,  32'h8000_0000);
    send_word(CMD_LINE_ERR, 8'h00, 32'h8000_0001);
    send_word(CMD_BYTE, HDR0,  32'h8000_0002);
    send_word(CMD_BYTE, HDR1,  32'h8000_0003);
    send_word(CMD_BYTE, 8'hAA, 32'h8000_0004);
    send_word(CMD_LINE_ERR, 8'h55, 32'hFFFF_FFFF);
  endtask

  // Channel extremes and a checksum mismatch, with the clock starting just below its wrap point
  task automatic test_channel_extremes();
    now_ms = 32'hFFFF_FFC0;
    send_frame('0, 1'b0, FRAME_BYTES);
    send_frame('1, 1'b0, FRAME_BYTES);
    send_frame(random_channels(), 1'b1, FRAME_BYTES);
    send_line_error(p_stamp + 32'd50);
  endtask

  // Online flag against each timeout, probed just inside and at the boundary
  task automatic test_timeout_settings();
    logic [31:0] settings [5];
    settings[0] = 32'd0;
    settings[1] = 32'd1;
    settings[2] = 32'hFFFF_FFFF;
    settings[3] = $urandom_range(2, 300);
    settings[4] = TIMEOUT_RST;
    foreach (settings[s]) begin
      write_timeout(settings[s]);
      send_frame(random_channels(), 1'b0, FRAME_BYTES);
      send_line_error(p_stamp + settings[s] - 32'd1);
      send_line_error(p_stamp + settings[s]);
      now_ms = p_stamp + settings[s];
    end
  endtask

  // Truncated frames cut short by line errors, then a clean frame
  task automatic test_broken_frames();
    send_frame(random_channels(), 1'b0, 17);
    send_line_error(advance_time());
    send_frame(random_channels(), 1'b0, FRAME_BYTES - 1);
    send_line_error(advance_time());
    send_frame(random_channels(), 1'b0, 1);
    send_line_error(advance_time());
    send_frame(random_channels(), 1'b0, FRAME_BYTES);
  endtask

  // Hold the output off for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    drain_results();
    sender_gaps_on = 1'b0;
    hold_req       = 1'b1;
    repeat (2) send_frame(random_channels(), 1'b0, FRAME_BYTES);
    send_line_error(advance_time());
    sender_gaps_on = 1'b1;
  endtask

  // Mostly well-formed frames with random content, some corrupt, cut or noisy
  task automatic test_random_traffic();
    int start;
    int r;
    int n;
    start = items_sent;
    while (items_sent - start < RANDOM_WORDS) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        send_frame(random_channels(), 1'b0, FRAME_BYTES);
      end else if (r == 7) begin
        send_frame(random_channels(), 1'b1, FRAME_BYTES);
      end else if (r == 8) begin
        send_frame(random_channels(), 1'b0, $urandom_range(1, FRAME_BYTES - 1));
        send_line_error(advance_time());
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          if ($urandom_range(0, 9) == 0) send_line_error(advance_time());
          else send_word(CMD_BYTE, 8'($urandom()), advance_time());
        end
        if ($urandom_range(0, 1) == 1) send_line_error(advance_time());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    p_pos     = '0;
    p_seen    = 1'b0;
    p_stamp   = '0;
    p_good    = '0;
    p_bad     = '0;
    p_timeout = TIMEOUT_RST;
    foreach (p_store[i]) p_store[i] = '0;

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_header_hunt();
    test_channel_extremes();
    test_timeout_settings();
    test_broken_frames();
    test_backpressure();
    write_timeout($urandom_range(1, 40));
    test_random_traffic();

    drain_results();

    $display("Covered %0d input words: %0d good frames, %0d checksum errors, %0d line errors.",
             items_sent, p_good, p_bad - line_errs, line_errs);
    $display("Checked %0d results over %0d timeout writes and one long output hold-off.",
             results_checked, cfg_writes);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
